// File: sv/sbb_pkg.sv
package sbb_pkg;

  // Shared byte memory depth and derived widths
  localparam int BUF_DEPTH = 64;
  localparam int PTR_W     = $clog2(BUF_DEPTH);
  localparam int LEN_W     = $clog2(BUF_DEPTH + 1);
  localparam int SUM_W     = LEN_W + 1;

  localparam int RING_SIZE_RESET = 64;

  // Operation codes
  localparam logic [2:0] OP_RX_PUSH = 3'd0;
  localparam logic [2:0] OP_RX_POP  = 3'd1;
  localparam logic [2:0] OP_TX_PUSH = 3'd2;
  localparam logic [2:0] OP_TX_POP  = 3'd3;
  localparam logic [2:0] OP_RX_PEEK = 3'd4;

  // Parity modes
  localparam logic [1:0] PAR_NONE = 2'd0;
  localparam logic [1:0] PAR_EVEN = 2'd1;
  localparam logic [1:0] PAR_ODD  = 2'd2;

  // Configuration register indexes
  localparam logic REG_RING_SIZE   = 1'b0;
  localparam logic REG_PARITY_MODE = 1'b1;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data_in;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  data_out;
    logic [7:0]  rx_count;
    logic [6:0]  tx_space;
    logic [15:0] rx_dropped_count;
    logic [15:0] tx_dropped_count;
  } out_t;

  // Ring size in use, clamped to 2..BUF_DEPTH
  function automatic logic [LEN_W-1:0] eff_size(input logic [7:0] ring);
    logic [LEN_W-1:0] s;
    if (ring < 8'd2) begin
      s = LEN_W'(2);
    end else if (ring > 8'(BUF_DEPTH)) begin
      s = LEN_W'(BUF_DEPTH);
    end else begin
      s = LEN_W'(ring);
    end
    return s;
  endfunction

  // Step a pointer forward modulo the ring size; by stays below the size
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [LEN_W-1:0] by,
                                               input logic [LEN_W-1:0] sz);
    logic [SUM_W-1:0] s;
    s = SUM_W'(p) + SUM_W'(by);
    if (s >= SUM_W'(sz)) begin
      s = s - SUM_W'(sz);
    end
    return PTR_W'(s);
  endfunction

  // Bytes not held by a ring of the given length
  function automatic logic [LEN_W-1:0] free_of(input logic [SUM_W-1:0] used,
                                               input logic [LEN_W-1:0] sz);
    logic [LEN_W-1:0] f;
    if (used < SUM_W'(sz)) begin
      f = LEN_W'(SUM_W'(sz) - used);
    end else begin
      f = '0;
    end
    return f;
  endfunction

  // Boundary move: half of the free span, rounded up
  function automatic logic [LEN_W-1:0] half_up(input logic [LEN_W-1:0] f);
    logic [SUM_W-1:0] s;
    s = (SUM_W'(f) + SUM_W'(1)) >> 1;
    return LEN_W'(s);
  endfunction

endpackage

// File: sv/sbb_ram.sv
module sbb_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/split_rx_tx_byte_buffer.sv
// Split receive/transmit byte buffer.
//
// One byte memory holds a receive ring and a transmit ring; the boundary
// between them moves when a push reaches the tail of an empty neighbor.
// Input transactions (in_data_i.op) push, pop or peek; every transaction
// returns exactly one result on the output channel carrying the status,
// the popped byte and the current counts.
//
// A transaction passes through the middle stage, which takes the memory read,
// and the output register. Throughput: one transaction per cycle unless the
// output stalls; the memory's single read port is used at most once per
// transaction and its registered output is consumed by the following stage.
// When the receiver stalls, the output register holds its result and one
// more transaction is taken into the middle stage; after that in_ready_o
// drops until the output is taken. Reset (rst_ni low) empties both rings,
// clears the drop counters and sets ring_size to 64 and parity_mode to none.
// Writing ring_size reinitializes pointers, lengths and counters. The user
// must write configuration only while idle; the block does not enforce it.
module split_rx_tx_byte_buffer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sbb_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sbb_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [7:0]    cfg_wdata_i
);

  import sbb_pkg::*;

  logic [7:0]       ring_size_q;
  logic [1:0]       parity_q;
  logic [PTR_W-1:0] rx_wp_q, rx_wp_d, rx_rp_q, rx_rp_d;
  logic [PTR_W-1:0] tx_wp_q, tx_wp_d, tx_rp_q, tx_rp_d;
  logic [LEN_W-1:0] rx_len_q, rx_len_d, tx_len_q, tx_len_d;
  logic [15:0]      rx_drop_q, rx_drop_d, tx_drop_q, tx_drop_d;

  logic             a_valid_q, a_rd_q;
  out_t             a_res_q, a_res_d;
  out_t             a_res_fwd;
  logic             out_valid_q;
  out_t             out_q;

  logic [LEN_W-1:0] sz, cfg_sz, free_rx, free_tx, free_n;
  logic             accept, a_move, par_on, fail, ok, pb;
  logic [7:0]       d;
  logic             wr_en, rd_en;
  logic [PTR_W-1:0] wr_addr, rd_addr;
  logic [7:0]       wr_data, rd_data;

  assign sz      = eff_size(ring_size_q);
  assign cfg_sz  = eff_size(cfg_wdata_i);
  assign free_rx = free_of(SUM_W'(rx_len_q), sz);
  assign free_tx = free_of(SUM_W'(tx_len_q), sz);
  assign par_on  = (parity_q == PAR_EVEN) || (parity_q == PAR_ODD);

  assign a_move     = a_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !a_valid_q || a_move;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    rx_wp_d   = rx_wp_q;
    rx_rp_d   = rx_rp_q;
    tx_wp_d   = tx_wp_q;
    tx_rp_d   = tx_rp_q;
    rx_len_d  = rx_len_q;
    tx_len_d  = tx_len_q;
    rx_drop_d = rx_drop_q;
    tx_drop_d = tx_drop_q;
    fail      = 1'b0;
    ok        = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = rx_wp_q;
    wr_data   = 8'h00;
    rd_en     = 1'b0;
    rd_addr   = rx_rp_q;
    d         = in_data_i.data_in;
    pb        = ~^in_data_i.data_in[6:0];

    if (accept) begin
      unique case (in_data_i.op) inside
        OP_RX_PUSH: begin
          if (rx_wp_q == tx_rp_q) begin
            if (tx_len_q != '0 || free_rx == '0) begin
              fail = 1'b1;
            end else begin
              tx_wp_d = advance(tx_wp_q, half_up(free_rx), sz);
              tx_rp_d = tx_wp_d;
            end
          end
          if (!fail && par_on) begin
            if ((parity_q == PAR_EVEN) ? (pb == d[7]) : (pb != d[7])) begin
              fail = 1'b1;
            end
            d[7] = 1'b0;
          end
          if (fail) begin
            rx_drop_d = rx_drop_q + 16'd1;
          end else begin
            wr_en    = 1'b1;
            wr_addr  = rx_wp_q;
            wr_data  = d;
            rx_wp_d  = advance(rx_wp_q, LEN_W'(1), sz);
            rx_len_d = rx_len_q + LEN_W'(1);
            ok       = 1'b1;
          end
        end
        OP_TX_PUSH: begin
          if (par_on) begin
            d[7] = (parity_q == PAR_EVEN) ? !pb : pb;
          end
          if (tx_wp_q == rx_rp_q) begin
            if (rx_len_q != '0 || free_tx == '0) begin
              fail = 1'b1;
            end else begin
              rx_wp_d = advance(rx_wp_q, half_up(free_tx), sz);
              rx_rp_d = rx_wp_d;
            end
          end
          if (fail) begin
            tx_drop_d = tx_drop_q + 16'd1;
          end else begin
            wr_en    = 1'b1;
            wr_addr  = tx_wp_q;
            wr_data  = d;
            tx_wp_d  = advance(tx_wp_q, LEN_W'(1), sz);
            tx_len_d = tx_len_q + LEN_W'(1);
            ok       = 1'b1;
          end
        end
        OP_RX_POP, OP_RX_PEEK: begin
          if (rx_len_q != '0) begin
            rd_en   = 1'b1;
            rd_addr = rx_rp_q;
            ok      = 1'b1;
            if (in_data_i.op == OP_RX_POP) begin
              rx_rp_d  = advance(rx_rp_q, LEN_W'(1), sz);
              rx_len_d = rx_len_q - LEN_W'(1);
            end
          end
        end
        OP_TX_POP: begin
          if (tx_len_q != '0) begin
            rd_en    = 1'b1;
            rd_addr  = tx_rp_q;
            ok       = 1'b1;
            tx_rp_d  = advance(tx_rp_q, LEN_W'(1), sz);
            tx_len_d = tx_len_q - LEN_W'(1);
          end
        end
        default: begin
        end
      endcase
    end

    free_n = free_of(SUM_W'(rx_len_d) + SUM_W'(tx_len_d), sz);

    a_res_d.ok               = ok;
    a_res_d.data_out         = 8'h00;
    a_res_d.rx_count         = 8'(rx_len_d);
    a_res_d.tx_space         = 7'(free_n >> 1);
    a_res_d.rx_dropped_count = rx_drop_d;
    a_res_d.tx_dropped_count = tx_drop_d;
  end

  sbb_ram #(
    .Width(8),
    .Depth(BUF_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_size_q <= 8'(RING_SIZE_RESET);
      parity_q    <= PAR_NONE;
      rx_wp_q     <= '0;
      rx_rp_q     <= '0;
      tx_wp_q     <= PTR_W'((eff_size(8'(RING_SIZE_RESET)) >> 1));
      tx_rp_q     <= PTR_W'((eff_size(8'(RING_SIZE_RESET)) >> 1));
      rx_len_q    <= '0;
      tx_len_q    <= '0;
      rx_drop_q   <= '0;
      tx_drop_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RING_SIZE: begin
          ring_size_q <= cfg_wdata_i;
          rx_wp_q     <= '0;
          rx_rp_q     <= '0;
          tx_wp_q     <= PTR_W'(cfg_sz >> 1);
          tx_rp_q     <= PTR_W'(cfg_sz >> 1);
          rx_len_q    <= '0;
          tx_len_q    <= '0;
          rx_drop_q   <= '0;
          tx_drop_q   <= '0;
        end
        REG_PARITY_MODE: begin
          parity_q <= cfg_wdata_i[1:0];
        end
        default: begin
        end
      endcase
    end else begin
      rx_wp_q   <= rx_wp_d;
      rx_rp_q   <= rx_rp_d;
      tx_wp_q   <= tx_wp_d;
      tx_rp_q   <= tx_rp_d;
      rx_len_q  <= rx_len_d;
      tx_len_q  <= tx_len_d;
      rx_drop_q <= rx_drop_d;
      tx_drop_q <= tx_drop_d;
    end
  end

  // Middle stage waits for the memory read; output register parts the sides
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (a_move) begin
        a_valid_q <= 1'b0;
      end
      if (a_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Merge the memory read data into the middle-stage result
  always_comb begin
    a_res_fwd          = a_res_q;
    a_res_fwd.data_out = a_rd_q ? rd_data : 8'h00;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_res_q <= a_res_d;
      a_rd_q  <= rd_en;
    end
    if (a_move) begin
      out_q <= a_res_fwd;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Both rings together never exceed the ring size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SUM_W'(rx_len_q) + SUM_W'(tx_len_q)) <= SUM_W'(sz))
    else $error("ring lengths exceed ring size");

  // Pointers stay inside the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SUM_W'(rx_wp_q) < SUM_W'(sz)) && (SUM_W'(tx_wp_q) < SUM_W'(sz)) &&
    (SUM_W'(rx_rp_q) < SUM_W'(sz)) && (SUM_W'(tx_rp_q) < SUM_W'(sz)))
    else $error("pointer outside ring");

  // A full pipeline with a stalled output takes no new transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("transaction accepted into a full pipeline");

  // A memory read is issued only when at least one ring holds a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> ((rx_len_q != '0) || (tx_len_q != '0)))
    else $error("read issued on empty rings");

endmodule

// File: tb/sv/tb_split_rx_tx_byte_buffer.sv
`timescale 1ns / 1ps

module tb_split_rx_tx_byte_buffer;
  import sbb_pkg::*;

  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [1:0] PAR_UNUSED      = 2'd3;
  localparam int         NUM_PHASES      = 10;
  localparam int         HOLD_CYCLES     = 60;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  in_t        in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_t       out_data_o;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_idx_i   = 1'b0;
  logic [7:0] cfg_wdata_i = '0;

  split_rx_tx_byte_buffer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Buffer state as the block should hold it
  logic [7:0]  byte_mem [BUF_DEPTH];
  int          rx_wp, rx_rp, tx_wp, tx_rp;
  int          rx_len, tx_len;
  logic [15:0] rx_drops, tx_drops;
  logic [7:0]  ring_reg;
  logic [1:0]  par_reg;

  in_t  ops_to_send [$];
  out_t owed_results [$];
  int   error_count   = 0;
  int   in_count      = 0;
  bit   in_took       = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_left     = 0;
  bit   hold_done     = 1'b0;

  function automatic int ring_span();
    int s;
    s = ring_reg;
    if (s < 2) s = 2;
    if (s > BUF_DEPTH) s = BUF_DEPTH;
    return s;
  endfunction

  function automatic int wrap_add(int p, int by, int sz);
    int q;
    q = p + by;
    while (q >= sz) q -= sz;
    return q;
  endfunction

  function automatic void reset_rings();
    int sz;
    sz = ring_span();
    rx_wp = 0;
    rx_rp = 0;
    tx_wp = sz / 2;
    tx_rp = sz / 2;
    rx_len = 0;
    tx_len = 0;
    rx_drops = '0;
    tx_drops = '0;
  endfunction

  function automatic out_t buffer_op_result(in_t item);
    int         sz;
    int         freeb;
    logic [7:0] d;
    logic [7:0] dout;
    logic       ok;
    logic       refused;
    logic       pb;
    out_t       res;
    sz = ring_span();
    d = item.data_in;
    dout = '0;
    ok = 1'b0;
    refused = 1'b0;
    case (item.op)
      OP_RX_PUSH: begin
        // Reaching the transmit tail: shove an empty transmit ring ahead
        if (rx_wp == tx_rp) begin
          freeb = (rx_len < sz) ? sz - rx_len : 0;
          if (tx_len != 0 || freeb == 0) begin
            refused = 1'b1;
          end else begin
            tx_wp = wrap_add(tx_wp, (freeb + 1) / 2, sz);
            tx_rp = tx_wp;
          end
        end
        if (!refused && (par_reg == PAR_EVEN || par_reg == PAR_ODD)) begin
          pb = ~^d[6:0];
          if (par_reg == PAR_EVEN ? (pb == d[7]) : (pb != d[7])) refused = 1'b1;
          d[7] = 1'b0;
        end
        if (refused) begin
          rx_drops++;
        end else begin
          byte_mem[rx_wp] = d;
          rx_wp = wrap_add(rx_wp, 1, sz);
          rx_len++;
          ok = 1'b1;
        end
      end
      OP_TX_PUSH: begin
        if (par_reg == PAR_EVEN || par_reg == PAR_ODD) begin
          pb = ~^d[6:0];
          d[7] = (par_reg == PAR_EVEN) ? !pb : pb;
        end
        if (tx_wp == rx_rp) begin
          freeb = (tx_len < sz) ? sz - tx_len : 0;
          if (rx_len != 0 || freeb == 0) begin
            refused = 1'b1;
          end else begin
            rx_wp = wrap_add(rx_wp, (freeb + 1) / 2, sz);
            rx_rp = rx_wp;
          end
        end
        if (refused) begin
          tx_drops++;
        end else begin
          byte_mem[tx_wp] = d;
          tx_wp = wrap_add(tx_wp, 1, sz);
          tx_len++;
          ok = 1'b1;
        end
      end
      OP_RX_POP, OP_RX_PEEK: begin
        if (rx_len != 0) begin
          dout = byte_mem[rx_rp];
          ok = 1'b1;
          if (item.op == OP_RX_POP) begin
            rx_rp = wrap_add(rx_rp, 1, sz);
            rx_len--;
          end
        end
      end
      OP_TX_POP: begin
        if (tx_len != 0) begin
          dout = byte_mem[tx_rp];
          ok = 1'b1;
          tx_rp = wrap_add(tx_rp, 1, sz);
          tx_len--;
        end
      end
      default: ;
    endcase
    freeb = sz - rx_len - tx_len;
    if (freeb < 0) freeb = 0;
    res.ok = ok;
    res.data_out = dout;
    res.rx_count = 8'(rx_len);
    res.tx_space = 7'(freeb >> 1);
    res.rx_dropped_count = rx_drops;
    res.tx_dropped_count = tx_drops;
    return res;
  endfunction

  task automatic note_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_result(input out_t got, input out_t exp);
    if (got.ok !== exp.ok)
      note_error($sformatf("ok got %0b exp %0b", got.ok, exp.ok));
    if (got.data_out !== exp.data_out)
      note_error($sformatf("data_out got %h exp %h", got.data_out, exp.data_out));
    if (got.rx_count !== exp.rx_count)
      note_error($sformatf("rx_count got %0d exp %0d", got.rx_count, exp.rx_count));
    if (got.tx_space !== exp.tx_space)
      note_error($sformatf("tx_space got %0d exp %0d", got.tx_space, exp.tx_space));
    if (got.rx_dropped_count !== exp.rx_dropped_count)
      note_error($sformatf("rx_dropped_count got %0d exp %0d",
                           got.rx_dropped_count, exp.rx_dropped_count));
    if (got.tx_dropped_count !== exp.tx_dropped_count)
      note_error($sformatf("tx_dropped_count got %0d exp %0d",
                           got.tx_dropped_count, exp.tx_dropped_count));
  endtask

  // Observe both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_took = in_valid_i && in_ready_o;
      if (in_took) begin
        owed_results.push_back(buffer_op_result(in_data_i));
        in_count++;
      end
      if (out_valid_o && out_ready_i) begin
        if (owed_results.size() == 0) begin
          note_error("result with no transaction pending");
        end else begin
          check_result(out_data_o, owed_results.pop_front());
        end
      end
    end
  end

  // Sender: hold the transaction until taken, then maybe idle
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (ops_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i <= ops_to_send.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to back up the pipeline
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (!hold_done && in_count >= 300 && ops_to_send.size() > 10) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_op(input logic [2:0] op, input logic [7:0] data);
    in_t item;
    item.op = op;
    item.data_in = data;
    ops_to_send.push_back(item);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    if (idx == REG_RING_SIZE) begin
      ring_reg = val;
      reset_rings();
    end else begin
      par_reg = val[1:0];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (ops_to_send.size() != 0 || in_valid_i || owed_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Random byte whose bit 7 passes (or fails) the current receive parity
  function automatic logic [7:0] framed_byte(input bit good);
    logic [7:0] d;
    logic       pb;
    d = 8'($urandom);
    if (par_reg == PAR_EVEN || par_reg == PAR_ODD) begin
      pb = ~^d[6:0];
      d[7] = (par_reg == PAR_EVEN) ? !pb : pb;
      if (!good) d[7] = !d[7];
    end
    return d;
  endfunction

  // Bias: 0 fill, 1 drain, 2 mixed
  function automatic logic [2:0] pick_op(input int bias);
    int r;
    r = $urandom_range(99);
    case (bias)
      0: begin
        if (r < 40) return OP_RX_PUSH;
        if (r < 75) return OP_TX_PUSH;
        if (r < 83) return OP_RX_POP;
        if (r < 91) return OP_TX_POP;
        if (r < 97) return OP_RX_PEEK;
      end
      1: begin
        if (r < 10) return OP_RX_PUSH;
        if (r < 20) return OP_TX_PUSH;
        if (r < 50) return OP_RX_POP;
        if (r < 80) return OP_TX_POP;
        if (r < 95) return OP_RX_PEEK;
      end
      default: begin
        if (r < 25) return OP_RX_PUSH;
        if (r < 50) return OP_TX_PUSH;
        if (r < 67) return OP_RX_POP;
        if (r < 84) return OP_TX_POP;
        if (r < 95) return OP_RX_PEEK;
      end
    endcase
    return OP_UNUSED_FIRST + 3'($urandom_range(2));
  endfunction

  initial begin
    int         phase_size [NUM_PHASES] = '{64, 2, 0, 255, 3, 65, 1, -1, 64, -2};
    int         phase_par  [NUM_PHASES] = '{0, 1, 2, 3, 0, 2, 1, -1, 1, -1};
    int         phase_len  [NUM_PHASES] = '{100, 100, 80, 150, 120, 150, 80, 150, 200, 150};
    int         bias;
    logic [7:0] size_val;
    logic [1:0] par_val;
    logic [2:0] op;
    ring_reg = 8'(RING_SIZE_RESET);
    par_reg = PAR_NONE;
    reset_rings();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 4) begin
        send_idle_pct = 15;
        recv_idle_pct = 50;
      end else if (p < 7) begin
        send_idle_pct = 50;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase_size[p] == -1) size_val = 8'($urandom_range(2, 16));
      else if (phase_size[p] == -2) size_val = 8'($urandom_range(255));
      else size_val = 8'(phase_size[p]);
      par_val = (phase_par[p] < 0) ? 2'($urandom_range(3)) : 2'(phase_par[p]);
      write_reg(REG_RING_SIZE, size_val);
      write_reg(REG_PARITY_MODE, {6'd0, par_val});
      if (p == 0) begin
        send_op(OP_RX_PUSH, 8'h00);
        send_op(OP_RX_PUSH, 8'hff);
        send_op(OP_RX_PEEK, 8'h00);
        send_op(OP_RX_POP, 8'h00);
        send_op(OP_RX_POP, 8'h00);
        send_op(OP_RX_POP, 8'h00);
        send_op(OP_TX_PUSH, 8'h80);
        send_op(OP_TX_PUSH, 8'h7f);
        send_op(OP_TX_POP, 8'h00);
        send_op(OP_TX_POP, 8'h00);
        send_op(OP_TX_POP, 8'h00);
        send_op(OP_RX_PEEK, 8'h00);
        for (int k = 0; k < 3; k++) send_op(OP_UNUSED_FIRST + 3'(k), 8'($urandom));
      end else if (p == 1) begin
        // Two-byte ring: fill it, refuse at a full memory, then bad parity
        send_op(OP_RX_PUSH, framed_byte(1'b1));
        send_op(OP_RX_PUSH, framed_byte(1'b1));
        send_op(OP_RX_PUSH, framed_byte(1'b1));
        send_op(OP_TX_PUSH, 8'h00);
        send_op(OP_RX_POP, 8'h00);
        send_op(OP_RX_POP, 8'h00);
        send_op(OP_RX_PUSH, framed_byte(1'b0));
        send_op(OP_TX_PUSH, 8'h01);
        send_op(OP_TX_POP, 8'h00);
      end
      bias = 2;
      for (int i = 0; i < phase_len[p]; i++) begin
        if (i % 16 == 0) bias = $urandom_range(2);
        op = pick_op(bias);
        if (op == OP_RX_PUSH) send_op(op, framed_byte($urandom_range(99) < 85));
        else send_op(op, 8'($urandom));
      end
      wait_drained();
    end
    if (owed_results.size() != 0)
      note_error($sformatf("%0d results never arrived", owed_results.size()));
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
